// ===== rtl/ssh_pkg.sv =====
// Shared types, constants and helper functions for the sample state histogram unit.
// No dependencies; every other file of the block imports this package.
package ssh_pkg;

  // Block sizing
  localparam int CHANNELS     = 16;
  localparam int SAMPLE_WIDTH = 16;
  localparam int SLOTS        = 8;
  localparam int CNT_W        = 32;
  localparam int CH_W         = 4;
  localparam int THR_W        = 15;
  localparam int SEL_W        = 2;

  // The channel field is four bits wide, so at most sixteen rows are reachable.
  localparam int ROWS   = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // Comparison width that holds the sample and the threshold with sign
  localparam int CMP_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 2;

  // Stream widths
  localparam int IN_TDATA_W  = 40;
  localparam int RES_W       = CH_W + (SLOTS + 1) * CNT_W;
  localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

  // Result queue
  localparam int Q_DEPTH = 3;
  localparam int QP_W    = $clog2(Q_DEPTH);
  localparam int LVL_W   = $clog2(Q_DEPTH + 1);

  // APB
  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [CNT_W-1:0] CNT_MAX         = {CNT_W{1'b1}};
  localparam logic [THR_W-1:0] LEVEL_THR_RESET = THR_W'(512);

  // Beat kind carried on tuser
  localparam logic FUNC_COUNT = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // Sample selection codes
  localparam logic [SEL_W-1:0] SEL_ALL  = 2'd0;
  localparam logic [SEL_W-1:0] SEL_EVEN = 2'd1;
  localparam logic [SEL_W-1:0] SEL_ODD  = 2'd2;

  typedef enum logic [1:0] {
    REG_TWO_BIT    = 2'd0,
    REG_COMPLEX    = 2'd1,
    REG_SAMPLE_SEL = 2'd2,
    REG_LEVEL_THR  = 2'd3
  } reg_idx_t;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

  typedef struct packed {
    logic              two_bit;
    logic              cplx;
    logic [SEL_W-1:0]  sel;
    logic [THR_W-1:0]  thr;
  } cfg_t;

  // Item as it sits in the counter update stage
  typedef struct packed {
    logic              valid;
    logic              rd;
    logic              ch_ok;
    logic [CH_W-1:0]   channel;
    logic [SLOTS-1:0]  mask;
    logic              blank;
  } stage_t;

  // Update command for one counter lane
  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
  } lane_upd_t;

  // One-hot quantizer state of a value; bit 0 is the most negative state.
  // 1-bit mode uses bits 0 (negative) and 1 (positive). Values on a bound give zero.
  function automatic logic [3:0] state_hot(input sample_t v, input logic two_bit,
                                           input logic [THR_W-1:0] thr);
    logic signed [CMP_W-1:0] vx;
    logic signed [CMP_W-1:0] tp;
    logic signed [CMP_W-1:0] tn;
    logic [3:0]              hot;
    vx  = CMP_W'(v);
    tp  = signed'(CMP_W'(thr));
    tn  = -tp;
    hot = 4'b0000;
    if (vx != '0) begin
      if (!two_bit) begin
        hot = (vx > 0) ? 4'b0010 : 4'b0001;
      end else if (vx > 0 && vx < tp) begin
        hot = 4'b0100;
      end else if (vx > tp) begin
        hot = 4'b1000;
      end else if (vx < 0 && vx > tn) begin
        hot = 4'b0010;
      end else if (vx < tn) begin
        hot = 4'b0001;
      end
    end
    return hot;
  endfunction

endpackage

// ===== rtl/sample_state_histogram_unit.sv =====
// Sample state histogram unit: per-channel quantizer state counters with a read-back stream.
// A read beat is registered into the update stage, where the lanes present its row; its
// result is then written into the result queue, from which the master side offers it.
// Throughput: one beat per cycle, count or read, unless the input holds off. The counter
// update loop is a registered RAM read with write-first bypass feeding a saturating increment.
// The input holds off only while three results, counting a read in flight, wait in the queue.
// Reset: registers return to defaults; all counters read as zero at once through per-row
// valid bits, so no clearing pass is needed. Depends on ssh_pkg, ssh_classify, ssh_lane,
// ssh_merge.
module sample_state_histogram_unit (
  input  logic                            clk,
  input  logic                            rst,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ssh_pkg::APB_AW-1:0]      paddr,
  input  logic [ssh_pkg::APB_DW-1:0]      pwdata,
  output logic [ssh_pkg::APB_DW-1:0]      prdata,
  output logic                            pready,
  // Sample stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [3:0] channel, [19:4] real_value, [35:20] imag_value, [36] sample_odd, [39:37] zero
  input  logic [ssh_pkg::IN_TDATA_W-1:0]  s_tdata,
  // [0] func
  input  logic                            s_tuser,
  // Counter read-back stream out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [3:0] channel_out, then count_real_0..3, count_imag_0..3, blank_count at 32 bits each,
  // [295:292] zero
  output logic [ssh_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import ssh_pkg::*;

  cfg_t                        cfg;
  reg_idx_t                    reg_idx;
  logic                        cfg_wr;
  logic                        take;
  stage_t                      stage;
  logic [SLOTS-1:0][CNT_W-1:0] counts;
  cnt_t                        blank_counter;
  logic [LVL_W-1:0]            level;
  logic [CH_W-1:0]             in_channel;

  // ---------------------------------------------------------------------------
  // Configuration registers; not enforced by the block: written by the user only while it is idle
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.two_bit <= 1'b1;
      cfg.cplx    <= 1'b0;
      cfg.sel     <= SEL_ALL;
      cfg.thr     <= LEVEL_THR_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TWO_BIT:    cfg.two_bit <= pwdata[0];
        REG_COMPLEX:    cfg.cplx    <= pwdata[0];
        REG_SAMPLE_SEL: cfg.sel     <= pwdata[SEL_W-1:0];
        REG_LEVEL_THR:  cfg.thr     <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TWO_BIT:    prdata = APB_DW'(cfg.two_bit);
      REG_COMPLEX:    prdata = APB_DW'(cfg.cplx);
      REG_SAMPLE_SEL: prdata = APB_DW'(cfg.sel);
      REG_LEVEL_THR:  prdata = APB_DW'(cfg.thr);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input side. Read beats hold a queue slot from acceptance onward, so the
  // update stage never stalls; count beats flow regardless of the output side
  // as long as the queue plus a read in flight leaves room.
  // ---------------------------------------------------------------------------
  assign s_tready   = ({1'b0, level} + (LVL_W + 1)'(stage.rd)) < (LVL_W + 1)'(Q_DEPTH);
  assign take       = s_tvalid && s_tready;
  assign in_channel = s_tdata[3:0];

  ssh_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .func       (s_tuser),
    .channel    (in_channel),
    .real_value (s_tdata[19:4]),
    .imag_value (s_tdata[35:20]),
    .sample_odd (s_tdata[36]),
    .cfg        (cfg),
    .stage      (stage)
  );

  // ---------------------------------------------------------------------------
  // Counter lanes: one per slot; each reads the row of the incoming beat at
  // the accept edge and writes its update from the registered update stage.
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < SLOTS; i++) begin : g_lane
    lane_upd_t upd;
    assign upd.en  = stage.mask[i];
    assign upd.row = stage.channel[ROW_AW-1:0];

    ssh_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .rd_row (in_channel[ROW_AW-1:0]),
      .upd    (upd),
      .count  (counts[i])
    );
  end

  // Shared blank counter, advanced in the update stage so reads see it in order
  always_ff @(posedge clk) begin
    if (rst) begin
      blank_counter <= '0;
    end else if (stage.blank && (blank_counter != CNT_MAX)) begin
      blank_counter <= blank_counter + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Merge lanes into result beats and queue them toward the master side
  // ---------------------------------------------------------------------------
  ssh_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .stage    (stage),
    .counts   (counts),
    .blank    (blank_counter),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .level    (level)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // A read reaching the merge stage always finds a free queue slot
  a_queue_room : assert property (@(posedge clk) disable iff (rst)
    stage.rd |-> level != LVL_W'(Q_DEPTH))
    else $error("result queue overflow");

  // An accepted read beat is in the update stage on the next cycle
  a_read_flow : assert property (@(posedge clk) disable iff (rst)
    (take && s_tuser == FUNC_READ) |=> (stage.valid && stage.rd))
    else $error("read beat lost before merge");

  // The blank counter saturates and never wraps
  a_blank_sat : assert property (@(posedge clk) disable iff (rst)
    (blank_counter == CNT_MAX) |=> (blank_counter == CNT_MAX))
    else $error("blank counter wrapped");

  // No result is offered right after reset
  a_reset_quiet : assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat offered after reset");

endmodule

// ===== rtl/ssh_classify.sv =====
// Input decode stage: sorts one accepted beat into counter slots and registers it.
// Depends on ssh_pkg.
module ssh_classify (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   take,
  input  logic                   func,
  input  logic [ssh_pkg::CH_W-1:0] channel,
  input  ssh_pkg::sample_t       real_value,
  input  ssh_pkg::sample_t       imag_value,
  input  logic                   sample_odd,
  input  ssh_pkg::cfg_t          cfg,
  output ssh_pkg::stage_t        stage
);
  import ssh_pkg::*;

  logic             ch_ok;
  logic             keep;
  logic             do_count;
  logic [3:0]       hot_re;
  logic [3:0]       hot_im;
  logic [SLOTS-1:0] mask;
  logic             blank;

  always_comb begin
    ch_ok    = 32'(channel) < CHANNELS;
    keep     = !((cfg.sel == SEL_EVEN) && sample_odd) && !((cfg.sel == SEL_ODD) && !sample_odd);
    do_count = take && (func == FUNC_COUNT) && ch_ok && keep;
    hot_re   = state_hot(real_value, cfg.two_bit, cfg.thr);
    hot_im   = state_hot(imag_value, cfg.two_bit, cfg.thr);
    if (!cfg.cplx) begin
      // zero real value goes to the shared blank counter only
      blank = (real_value == '0);
      mask  = {4'b0000, hot_re};
    end else if (cfg.two_bit) begin
      blank = 1'b0;
      mask  = {hot_im, hot_re};
    end else begin
      blank = 1'b0;
      mask  = {4'b0000, hot_im[1:0], hot_re[1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
    end else begin
      stage.valid   <= take;
      stage.rd      <= take && (func == FUNC_READ);
      stage.ch_ok   <= ch_ok;
      stage.channel <= channel;
      stage.mask    <= do_count ? mask : '0;
      stage.blank   <= do_count && blank;
    end
  end

endmodule

// ===== rtl/ssh_lane.sv =====
// One counter lane: a row of saturating 32-bit counters, one per channel, for one slot.
// Depends on ssh_pkg.
module ssh_lane (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [ssh_pkg::ROW_AW-1:0] rd_row,
  input  ssh_pkg::lane_upd_t       upd,
  output ssh_pkg::cnt_t            count
);
  import ssh_pkg::*;

  cnt_t            mem [ROWS];
  logic [ROWS-1:0] row_valid;
  cnt_t            rd_data;
  logic            rd_valid;
  cnt_t            cur;
  cnt_t            nxt;
  logic            bypass;

  // Unwritten rows read as zero
  assign cur    = rd_valid ? rd_data : '0;
  assign nxt    = (cur == CNT_MAX) ? cur : cur + CNT_W'(1);
  assign bypass = upd.en && (upd.row == rd_row);
  assign count  = cur;

  // Write-first read so a beat right behind an update of the same row sees it
  always_ff @(posedge clk) begin
    if (upd.en) begin
      mem[upd.row] <= nxt;
    end
    rd_data <= bypass ? nxt : mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (upd.en) begin
        row_valid[upd.row] <= 1'b1;
      end
      rd_valid <= row_valid[rd_row] | bypass;
    end
  end

endmodule

// ===== rtl/ssh_merge.sv =====
// Merge stage: gathers the lane counters and blank count into result beats and queues them.
// Depends on ssh_pkg.
module ssh_merge (
  input  logic                            clk,
  input  logic                            rst,
  input  ssh_pkg::stage_t                 stage,
  input  logic [ssh_pkg::SLOTS-1:0][ssh_pkg::CNT_W-1:0] counts,
  input  ssh_pkg::cnt_t                   blank,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ssh_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [ssh_pkg::LVL_W-1:0]       level
);
  import ssh_pkg::*;

  logic [RES_W-1:0]              q [Q_DEPTH];
  logic [QP_W-1:0]               head;
  logic [QP_W-1:0]               tail;
  logic                          push;
  logic                          pop;
  logic [SLOTS-1:0][CNT_W-1:0]   shown;
  logic [RES_W-1:0]              entry;

  assign push     = stage.rd;
  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = (level != '0);
  // Out-of-range channels report zero counters
  assign shown    = stage.ch_ok ? counts : '0;
  assign entry    = {blank, shown, stage.channel};
  assign m_tdata  = OUT_TDATA_W'(q[head]);

  function automatic logic [QP_W-1:0] wrap_inc(input logic [QP_W-1:0] p);
    return (p == QP_W'(Q_DEPTH - 1)) ? '0 : p + QP_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      q[tail] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      level <= level + LVL_W'(push) - LVL_W'(pop);
    end
  end

endmodule
